// ===== design/masked_byte_signature_matcher_unit_macros.svh =====
// assertion macros used by the signature matcher rtl
// depends on a clock named i_clk and an active-low reset named i_rst_n in the user
`ifndef MASKED_BYTE_SIGNATURE_MATCHER_UNIT_MACROS_SVH
`define MASKED_BYTE_SIGNATURE_MATCHER_UNIT_MACROS_SVH

// clocked check, off while reset is held
`define MBSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define MBSM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== design/mbsm_pkg.sv =====
// shared types and constants for the masked byte signature matcher
// no dependencies
package mbsm_pkg;

    localparam int BYTE_W     = 8;
    localparam int PATTERN_W  = 64;
    localparam int MASK_W     = 8;
    localparam int LENGTH_W   = 4;
    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int OUT_DATA_W = ADDR_W + PATTERN_W;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_WILDCARD_MASK  = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2,
        CFG_BASE_ADDRESS   = 2'd3
    } t_cfg_index;

    // current configuration as seen by the datapath
    typedef struct packed {
        logic [PATTERN_W-1:0] pattern_bytes;
        logic [MASK_W-1:0]    wildcard_mask;
        logic [LENGTH_W-1:0]  pattern_length;
        logic [ADDR_W-1:0]    base_address;
    } t_cfg;

    // one reported match
    typedef struct packed {
        logic [PATTERN_W-1:0] matched_bytes;
        logic [ADDR_W-1:0]    match_address;
    } t_match;

endpackage

// ===== design/mbsm_cfg_regs.sv =====
// configuration registers of the signature matcher
// depends on mbsm_pkg
module mbsm_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mbsm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mbsm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mbsm_pkg::t_cfg                 o_cfg
);
    import mbsm_pkg::*;

    t_cfg r_cfg;

    // register writes, low bits of the data kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_bytes  <= '0;
            r_cfg.wildcard_mask  <= '0;
            r_cfg.pattern_length <= LENGTH_W'(1);
            r_cfg.base_address   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PATTERN_BYTES:  r_cfg.pattern_bytes  <= i_cfg_data[PATTERN_W-1:0];
                CFG_WILDCARD_MASK:  r_cfg.wildcard_mask  <= i_cfg_data[MASK_W-1:0];
                CFG_PATTERN_LENGTH: r_cfg.pattern_length <= i_cfg_data[LENGTH_W-1:0];
                CFG_BASE_ADDRESS:   r_cfg.base_address   <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/mbsm_match_core.sv =====
// byte window, region counter and masked compare of the signature matcher
// depends on mbsm_pkg
module mbsm_match_core #(
    parameter int MAX_PATTERN_BYTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mbsm_pkg::t_cfg              i_cfg,
    input  logic                        i_accept,
    input  logic [mbsm_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_last,
    output logic                        o_hit,
    output mbsm_pkg::t_match            o_match
);
    import mbsm_pkg::*;

    localparam int WIN_DEPTH = MAX_PATTERN_BYTES - 1;
    localparam int IDX_W     = $clog2(MAX_PATTERN_BYTES);

    logic [BYTE_W-1:0]   r_window [WIN_DEPTH];
    logic [COUNT_W-1:0]  r_count;

    logic [BYTE_W-1:0]   hist [MAX_PATTERN_BYTES];
    logic [LENGTH_W-1:0] len_eff;
    logic [COUNT_W-1:0]  count_inc;
    logic                enough;
    logic                all_ok;
    logic [PATTERN_W-1:0] matched;

    // clamp the length to 1..max
    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            len_eff = LENGTH_W'(1);
        end else if (i_cfg.pattern_length > LENGTH_W'(MAX_PATTERN_BYTES)) begin
            len_eff = LENGTH_W'(MAX_PATTERN_BYTES);
        end else begin
            len_eff = i_cfg.pattern_length;
        end
    end

    // history view: entry 0 is the current byte
    always_comb begin
        hist[0] = i_data_byte;
        for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
            hist[j] = r_window[j-1];
        end
    end

    assign count_inc = r_count + COUNT_W'(1);
    assign enough    = (count_inc >= COUNT_W'(len_eff));

    // per-position masked compare
    always_comb begin
        logic [LENGTH_W-1:0] sel;
        logic [BYTE_W-1:0]   cand;
        logic                used;
        all_ok  = 1'b1;
        matched = '0;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            sel  = len_eff - LENGTH_W'(i) - LENGTH_W'(1);
            cand = hist[sel[IDX_W-1:0]];
            used = (LENGTH_W'(i) < len_eff) && !i_cfg.wildcard_mask[i];
            if (used) begin
                if (cand != i_cfg.pattern_bytes[BYTE_W*i +: BYTE_W]) begin
                    all_ok = 1'b0;
                end
                matched[BYTE_W*i +: BYTE_W] = cand;
            end
        end
    end

    assign o_hit                 = i_accept && enough && all_ok;
    assign o_match.matched_bytes = matched;
    assign o_match.match_address = i_cfg.base_address + (count_inc - COUNT_W'(len_eff));

    // window shift and region counter, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < WIN_DEPTH; k++) begin
                r_window[k] <= '0;
            end
        end else if (i_accept) begin
            if (i_last) begin
                r_count <= '0;
                for (int k = 0; k < WIN_DEPTH; k++) begin
                    r_window[k] <= '0;
                end
            end else begin
                r_count     <= count_inc;
                r_window[0] <= i_data_byte;
                for (int k = 1; k < WIN_DEPTH; k++) begin
                    r_window[k] <= r_window[k-1];
                end
            end
        end
    end

endmodule

// ===== design/mbsm_out_stage.sv =====
// result register with one skid entry for the signature matcher
// depends on mbsm_pkg and the assertion macro header
module mbsm_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mbsm_pkg::t_match i_match,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_pop_ready,
    output mbsm_pkg::t_match o_match
);
    import mbsm_pkg::*;
    `include "masked_byte_signature_matcher_unit_macros.svh"

    logic   r_out_valid;
    logic   r_skid_valid;
    t_match r_out;
    t_match r_skid;
    logic   pop;

    assign pop     = r_out_valid && i_pop_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_match = r_out;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload moves, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out <= i_match;
            end else begin
                r_skid <= i_match;
            end
        end
    end

    // skid entry only fills behind a held result
    `MBSM_ASSERT(a_skid_needs_out, r_skid_valid |-> r_out_valid, "skid full with empty output")
    // no new result while the skid entry is occupied
    `MBSM_ASSERT(a_no_push_when_full, i_push |-> !r_skid_valid, "result pushed into full stage")
    // a waiting skid entry always leaves a valid output behind it
    `MBSM_ASSERT(a_skid_drains_to_out, r_skid_valid |=> r_out_valid, "skid entry lost")

endmodule

// ===== design/masked_byte_signature_matcher_unit.sv =====
// a matching byte's result is registered in the output stage before m_axis shows it
// throughput: one byte per cycle; the single-pass compare and a two-entry
// output stage (result register plus skid) let a byte in every cycle while
// the sink takes results; the sink stalling two results closes tready
// reset (synchronous, active low): registers to their reset values, window and
// byte counter to zero, output stage empty
module masked_byte_signature_matcher_unit #(
    parameter int MAX_PATTERN_BYTES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [mbsm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbsm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // byte stream in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // data_byte
    input  logic                             s_axis_tlast,   // last_of_region
    // match results out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mbsm_pkg::OUT_DATA_W-1:0]  m_axis_tdata    // matched_bytes, match_address
);
    import mbsm_pkg::*;

    t_cfg   cfg;
    t_match core_match;
    t_match out_match;
    logic   accept;
    logic   hit;
    logic   stage_ready;

    assign accept        = s_axis_tvalid && stage_ready;
    assign s_axis_tready = stage_ready;

    // configuration registers
    mbsm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // window and compare
    mbsm_match_core #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_data_byte (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_hit       (hit),
        .o_match     (core_match)
    );

    // result register and skid
    mbsm_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (hit),
        .i_match     (core_match),
        .o_ready     (stage_ready),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_match     (out_match)
    );

    assign m_axis_tdata = {out_match.matched_bytes, out_match.match_address};

endmodule
